### design/cqm_pkg.sv
// Shared types, constants and the arctangent table for the cell quality metrics block.
package cqm_pkg;

  localparam int CoordW   = 16;
  localparam int EdgeW    = CoordW + 1;
  localparam int JacW     = 52;
  localparam int AngW     = 15;
  localparam int StepW    = 25;
  localparam int CordSteps = 23;
  localparam int CordW    = 34;
  localparam int ZW       = 25;
  localparam int SqW      = 64;
  localparam int RootW    = 32;
  localparam int SqrtSteps = 32;
  localparam logic [ZW-1:0] AngMaxQ16 = ZW'(90 * 65536);
  localparam logic [AngW-1:0] AngMaxQ8 = AngW'(23040);

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [EdgeW-1:0] edge_t;
  typedef struct packed {
    edge_t x;
    edge_t y;
    edge_t z;
  } vec_t;

  typedef struct packed {
    logic signed [JacW-1:0] jacobian;
    logic [AngW-1:0]        orth_xi_eta;
    logic [AngW-1:0]        orth_xi_zeta;
    logic [AngW-1:0]        orth_eta_zeta;
    logic [StepW-1:0]       step_xi;
    logic [StepW-1:0]       step_eta;
    logic [StepW-1:0]       step_zeta;
    logic                   degenerate;
  } result_t;

  function automatic logic [ZW-1:0] atan_q16(input int idx);
    logic [ZW-1:0] t;
    begin
      unique case (idx)
        0: t = ZW'(2949120);  1: t = ZW'(1740967);  2: t = ZW'(919879);
        3: t = ZW'(466945);   4: t = ZW'(234379);   5: t = ZW'(117304);
        6: t = ZW'(58666);    7: t = ZW'(29335);    8: t = ZW'(14668);
        9: t = ZW'(7334);     10: t = ZW'(3667);    11: t = ZW'(1833);
        12: t = ZW'(917);     13: t = ZW'(458);     14: t = ZW'(229);
        15: t = ZW'(115);     16: t = ZW'(57);      17: t = ZW'(29);
        18: t = ZW'(14);      19: t = ZW'(7);       20: t = ZW'(4);
        21: t = ZW'(2);       22: t = ZW'(1);
        default: t = '0;
      endcase
      return t;
    end
  endfunction

endpackage

### design/cqm_if.sv
// Valid/ready channel interfaces carrying cell points and metric results.
interface cqm_in_if;
  import cqm_pkg::*;
  logic   valid;
  logic   ready;
  coord_t base_x, base_y, base_z;
  coord_t xi_nbr_x, xi_nbr_y, xi_nbr_z;
  coord_t eta_nbr_x, eta_nbr_y, eta_nbr_z;
  coord_t zeta_nbr_x, zeta_nbr_y, zeta_nbr_z;
  modport source (output valid, base_x, base_y, base_z, xi_nbr_x, xi_nbr_y, xi_nbr_z,
                  eta_nbr_x, eta_nbr_y, eta_nbr_z, zeta_nbr_x, zeta_nbr_y, zeta_nbr_z,
                  input ready);
  modport sink (input valid, base_x, base_y, base_z, xi_nbr_x, xi_nbr_y, xi_nbr_z,
                eta_nbr_x, eta_nbr_y, eta_nbr_z, zeta_nbr_x, zeta_nbr_y, zeta_nbr_z,
                output ready);
endinterface

interface cqm_out_if;
  import cqm_pkg::*;
  logic    valid;
  logic    ready;
  result_t res;
  modport source (output valid, res, input ready);
  modport sink (input valid, res, output ready);
endinterface

### design/cqm_sqrt_cell.sv
// One restoring square root step: consumes two radicand bits, yields one root bit.
module cqm_sqrt_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [cqm_pkg::SqW-1:0]   rad_i,
  input  logic [cqm_pkg::RootW+1:0] rem_i,
  input  logic [cqm_pkg::RootW-1:0] root_i,
  output logic [cqm_pkg::SqW-1:0]   rad_o,
  output logic [cqm_pkg::RootW+1:0] rem_o,
  output logic [cqm_pkg::RootW-1:0] root_o
);
  import cqm_pkg::*;

  logic [RootW+1:0] trial;
  logic [RootW+1:0] trial_sub;
  logic [RootW+1:0] rem_nxt;
  logic [RootW-1:0] root_nxt;
  logic [SqW-1:0]   rad_r;
  logic [RootW+1:0] rem_r;
  logic [RootW-1:0] root_r;

  always_comb begin
    trial     = {rem_i[RootW-1:0], rad_i[SqW-1 -: 2]};
    trial_sub = {root_i, 2'b01};
    if (trial >= trial_sub) begin
      rem_nxt  = trial - trial_sub;
      root_nxt = {root_i[RootW-2:0], 1'b1};
    end else begin
      rem_nxt  = trial;
      root_nxt = {root_i[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[SqW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
endmodule

### design/cqm_cordic_cell.sv
// One CORDIC vectoring micro-rotation with a fixed shift; registered.
module cqm_cordic_cell (
  input  logic                             clk,
  input  logic                             en,
  input  logic [4:0]                       shift,
  input  logic [cqm_pkg::ZW-1:0]           atan_val,
  input  logic signed [cqm_pkg::CordW-1:0] x_i,
  input  logic signed [cqm_pkg::CordW-1:0] y_i,
  input  logic signed [cqm_pkg::ZW:0]      z_i,
  output logic signed [cqm_pkg::CordW-1:0] x_o,
  output logic signed [cqm_pkg::CordW-1:0] y_o,
  output logic signed [cqm_pkg::ZW:0]      z_o
);
  import cqm_pkg::*;

  logic signed [CordW-1:0] xs, ys;
  logic signed [CordW-1:0] x_r, y_r;
  logic signed [ZW:0]      z_r;

  // shift toward zero on the magnitude
  function automatic logic signed [CordW-1:0] shr_tz(input logic signed [CordW-1:0] v,
                                                     input logic [4:0] s);
    logic [CordW-1:0] m;
    begin
      m = v[CordW-1] ? CordW'(-v) : v;
      m = m >> s;
      return v[CordW-1] ? -$signed(m) : $signed(m);
    end
  endfunction

  always_comb begin
    xs = shr_tz(x_i, shift);
    ys = shr_tz(y_i, shift);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_i[CordW-1]) begin
        x_r <= x_i + ys;
        y_r <= y_i - xs;
        z_r <= z_i + $signed({1'b0, atan_val});
      end else begin
        x_r <= x_i - ys;
        y_r <= y_i + xs;
        z_r <= z_i - $signed({1'b0, atan_val});
      end
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
endmodule

### design/cqm_angle.sv
// Folded angle of one edge pair: products, normalize, root of cross norm, CORDIC chain.
module cqm_angle (
  input  logic                clk,
  input  logic                en,
  input  cqm_pkg::vec_t       u,
  input  cqm_pkg::vec_t       v,
  output logic [cqm_pkg::AngW-1:0] angle
);
  import cqm_pkg::*;

  localparam int PW = 2 * EdgeW;      // product width
  localparam int SW = PW + 1;         // sum width, signed
  localparam int MW = PW + 1;         // magnitude width

  // stage 1: products
  logic signed [PW-1:0] p_r [9];
  // stage 2: sums as magnitudes
  logic [MW-1:0] ad_r, ax_r, ay_r, az_r;
  // stage 3: normalized
  logic [29:0] nd_r, nx_r, ny_r, nz_r;
  // stage 4: squares
  logic [59:0] sx_r, sy_r, sz_r;
  logic [29:0] d4_r;
  // stage 5: sum
  logic [SqW-1:0] rad5_r;
  logic [29:0]    d5_r;

  logic signed [SW-1:0] d_s, wx_s, wy_s, wz_s;
  logic [MW-1:0] mx;
  logic [4:0]    sh;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= u.x * v.x;  p_r[1] <= u.y * v.y;  p_r[2] <= u.z * v.z;
      p_r[3] <= u.y * v.z;  p_r[4] <= u.z * v.y;
      p_r[5] <= u.z * v.x;  p_r[6] <= u.x * v.z;
      p_r[7] <= u.x * v.y;  p_r[8] <= u.y * v.x;
    end
  end

  always_comb begin
    d_s  = SW'(p_r[0]) + SW'(p_r[1]) + SW'(p_r[2]);
    wx_s = SW'(p_r[3]) - SW'(p_r[4]);
    wy_s = SW'(p_r[5]) - SW'(p_r[6]);
    wz_s = SW'(p_r[7]) - SW'(p_r[8]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ad_r <= d_s[SW-1]  ? MW'(-d_s)  : MW'(d_s);
      ax_r <= wx_s[SW-1] ? MW'(-wx_s) : MW'(wx_s);
      ay_r <= wy_s[SW-1] ? MW'(-wy_s) : MW'(wy_s);
      az_r <= wz_s[SW-1] ? MW'(-wz_s) : MW'(wz_s);
    end
  end

  always_comb begin
    mx = ad_r | ax_r | ay_r | az_r;
    sh = '0;
    for (int k = 30; k < MW; k++) begin
      if (mx[k]) sh = 5'(k - 29);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nd_r <= 30'(ad_r >> sh);
      nx_r <= 30'(ax_r >> sh);
      ny_r <= 30'(ay_r >> sh);
      nz_r <= 30'(az_r >> sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= nx_r * nx_r;
      sy_r <= ny_r * ny_r;
      sz_r <= nz_r * nz_r;
      d4_r <= nd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad5_r <= SqW'(sx_r) + SqW'(sy_r) + SqW'(sz_r);
      d5_r   <= d4_r;
    end
  end

  // square root chain, X travels alongside
  logic [SqW-1:0]   q_rad  [SqrtSteps+1];
  logic [RootW+1:0] q_rem  [SqrtSteps+1];
  logic [RootW-1:0] q_root [SqrtSteps+1];
  logic [29:0]      q_d_r  [SqrtSteps+1];

  assign q_rad[0]  = rad5_r;
  assign q_rem[0]  = '0;
  assign q_root[0] = '0;
  assign q_d_r[0]  = d5_r;

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    cqm_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .rad_i  (q_rad[g]),
      .rem_i  (q_rem[g]),
      .root_i (q_root[g]),
      .rad_o  (q_rad[g+1]),
      .rem_o  (q_rem[g+1]),
      .root_o (q_root[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) q_d_r[g+1] <= q_d_r[g];
    end
  end

  logic signed [CordW-1:0] cx [CordSteps+1];
  logic signed [CordW-1:0] cy [CordSteps+1];
  logic signed [ZW:0]      cz [CordSteps+1];

  assign cx[0] = CordW'($signed({1'b0, q_d_r[SqrtSteps]}));
  assign cy[0] = CordW'($signed({1'b0, q_root[SqrtSteps]}));
  assign cz[0] = '0;

  for (genvar g = 0; g < CordSteps; g++) begin : g_cord
    cqm_cordic_cell u_cell (
      .clk      (clk),
      .en       (en),
      .shift    (5'(g)),
      .atan_val (atan_q16(g)),
      .x_i      (cx[g]),
      .y_i      (cy[g]),
      .z_i      (cz[g]),
      .x_o      (cx[g+1]),
      .y_o      (cy[g+1]),
      .z_o      (cz[g+1])
    );
  end

  logic [ZW-1:0] zc;
  logic [ZW-1:0] q;
  always_comb begin
    if (cz[CordSteps][ZW]) zc = '0;
    else if (cz[CordSteps][ZW-1:0] > AngMaxQ16) zc = AngMaxQ16;
    else zc = cz[CordSteps][ZW-1:0];
    q = (zc + ZW'(128)) >> 8;
  end

  logic [AngW-1:0] ang_r;
  always_ff @(posedge clk) begin
    if (en) ang_r <= (q > ZW'(AngMaxQ8)) ? AngMaxQ8 : AngW'(q);
  end
  assign angle = ang_r;
endmodule

### design/cqm_step.sv
// Edge length in Q.8: squared norm, square root chain, round and saturate.
module cqm_step (
  input  logic                      clk,
  input  logic                      en,
  input  cqm_pkg::vec_t             e,
  output logic [cqm_pkg::StepW-1:0] step
);
  import cqm_pkg::*;

  localparam int PW = 2 * EdgeW;

  logic [PW-1:0] sq_r [3];
  logic [SqW-1:0] rad_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= PW'(e.x * e.x);
      sq_r[1] <= PW'(e.y * e.y);
      sq_r[2] <= PW'(e.z * e.z);
      rad_r   <= (SqW'(sq_r[0]) + SqW'(sq_r[1]) + SqW'(sq_r[2])) << 16;
    end
  end

  logic [SqW-1:0]   q_rad  [SqrtSteps+1];
  logic [RootW+1:0] q_rem  [SqrtSteps+1];
  logic [RootW-1:0] q_root [SqrtSteps+1];

  assign q_rad[0]  = rad_r;
  assign q_rem[0]  = '0;
  assign q_root[0] = '0;

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    cqm_sqrt_cell u_cell (
      .clk    (clk),
      .en     (en),
      .rad_i  (q_rad[g]),
      .rem_i  (q_rem[g]),
      .root_i (q_root[g]),
      .rad_o  (q_rad[g+1]),
      .rem_o  (q_rem[g+1]),
      .root_o (q_root[g+1])
    );
  end

  // remainder above root means the root lies past the half point
  logic [RootW:0] rnd;
  always_comb begin
    rnd = {1'b0, q_root[SqrtSteps]} +
          ((q_rem[SqrtSteps] > {2'b00, q_root[SqrtSteps]}) ? (RootW+1)'(1) : '0);
  end

  logic [StepW-1:0] step_r;
  always_ff @(posedge clk) begin
    if (en) step_r <= (rnd > (RootW+1)'({StepW{1'b1}})) ? {StepW{1'b1}} : StepW'(rnd);
  end
  assign step = step_r;
endmodule

### design/cell_quality_metrics.sv
// Top level: edge vectors, Jacobian, three angle chains and three length chains.
// Throughput: one cell per clock; the whole datapath is a row of registers, including the
// square root and CORDIC cells, that all advance together while the output is free.
// Stall: when the result is not taken the entire pipeline holds.
// Reset: rst_n synchronous, clears the per-stage valid bits only.
module cell_quality_metrics (
  input  logic clk,
  input  logic rst_n,
  cqm_in_if.sink    in_ch,
  cqm_out_if.source out_ch
);
  import cqm_pkg::*;

  // 1 edge, 5 angle front, 32 sqrt, 23 cordic, 1 angle out, 1 output
  localparam int Lat = 63;
  localparam int AngLat = 61;   // edge register to angle valid
  localparam int StepLat = 35;

  logic en;
  logic [Lat-1:0] vld_r;

  assign en          = !vld_r[Lat-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_ch.valid};
    end
  end

  vec_t ea_r, eb_r, ec_r;
  logic degen_r;

  function automatic edge_t sub(input coord_t a, input coord_t b);
    return EdgeW'(a) - EdgeW'(b);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ea_r <= '{sub(in_ch.xi_nbr_x, in_ch.base_x), sub(in_ch.xi_nbr_y, in_ch.base_y),
                sub(in_ch.xi_nbr_z, in_ch.base_z)};
      eb_r <= '{sub(in_ch.eta_nbr_x, in_ch.base_x), sub(in_ch.eta_nbr_y, in_ch.base_y),
                sub(in_ch.eta_nbr_z, in_ch.base_z)};
      ec_r <= '{sub(in_ch.zeta_nbr_x, in_ch.base_x), sub(in_ch.zeta_nbr_y, in_ch.base_y),
                sub(in_ch.zeta_nbr_z, in_ch.base_z)};
      degen_r <= (in_ch.xi_nbr_x == in_ch.base_x && in_ch.xi_nbr_y == in_ch.base_y &&
                  in_ch.xi_nbr_z == in_ch.base_z) ||
                 (in_ch.eta_nbr_x == in_ch.base_x && in_ch.eta_nbr_y == in_ch.base_y &&
                  in_ch.eta_nbr_z == in_ch.base_z) ||
                 (in_ch.zeta_nbr_x == in_ch.base_x && in_ch.zeta_nbr_y == in_ch.base_y &&
                  in_ch.zeta_nbr_z == in_ch.base_z);
    end
  end

  // Jacobian: cross product, then dot with zeta edge
  localparam int CW = 2 * EdgeW + 1;
  logic signed [2*EdgeW-1:0] jp_r [6];
  vec_t ec2_r;
  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  vec_t ec3_r;
  logic signed [JacW-1:0] jt_r [3];
  logic signed [JacW-1:0] jac_r;

  always_ff @(posedge clk) begin
    if (en) begin
      jp_r[0] <= ea_r.y * eb_r.z;  jp_r[1] <= ea_r.z * eb_r.y;
      jp_r[2] <= ea_r.z * eb_r.x;  jp_r[3] <= ea_r.x * eb_r.z;
      jp_r[4] <= ea_r.x * eb_r.y;  jp_r[5] <= ea_r.y * eb_r.x;
      ec2_r   <= ec_r;
      cx_r    <= CW'(jp_r[0]) - CW'(jp_r[1]);
      cy_r    <= CW'(jp_r[2]) - CW'(jp_r[3]);
      cz_r    <= CW'(jp_r[4]) - CW'(jp_r[5]);
      ec3_r   <= ec2_r;
      jt_r[0] <= JacW'(cx_r * ec3_r.x);
      jt_r[1] <= JacW'(cy_r * ec3_r.y);
      jt_r[2] <= JacW'(cz_r * ec3_r.z);
      jac_r   <= jt_r[0] + jt_r[1] + jt_r[2];
    end
  end

  // delay lines to align with the angle chain; the Jacobian takes four stages
  localparam int JacDly = AngLat - 4;
  logic signed [JacW-1:0] jac_d [JacDly];
  logic degen_d [AngLat];
  logic [StepW-1:0] st_d [3][AngLat-StepLat];

  always_ff @(posedge clk) begin
    if (en) begin
      jac_d[0]   <= jac_r;
      degen_d[0] <= degen_r;
      for (int k = 1; k < JacDly; k++) jac_d[k] <= jac_d[k-1];
      for (int k = 1; k < AngLat; k++) degen_d[k] <= degen_d[k-1];
    end
  end

  logic [AngW-1:0] ang_ab, ang_ac, ang_bc;
  logic [StepW-1:0] st [3];

  cqm_angle u_ang_ab (.clk(clk), .en(en), .u(ea_r), .v(eb_r), .angle(ang_ab));
  cqm_angle u_ang_ac (.clk(clk), .en(en), .u(ea_r), .v(ec_r), .angle(ang_ac));
  cqm_angle u_ang_bc (.clk(clk), .en(en), .u(eb_r), .v(ec_r), .angle(ang_bc));

  cqm_step u_st_a (.clk(clk), .en(en), .e(ea_r), .step(st[0]));
  cqm_step u_st_b (.clk(clk), .en(en), .e(eb_r), .step(st[1]));
  cqm_step u_st_c (.clk(clk), .en(en), .e(ec_r), .step(st[2]));

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        st_d[j][0] <= st[j];
        for (int k = 1; k < AngLat - StepLat; k++) st_d[j][k] <= st_d[j][k-1];
      end
    end
  end

  result_t res_r;
  always_ff @(posedge clk) begin
    if (en) begin
      res_r.jacobian      <= jac_d[JacDly-1];
      res_r.degenerate    <= degen_d[AngLat-1];
      res_r.orth_xi_eta   <= degen_d[AngLat-1] ? '0 : ang_ab;
      res_r.orth_xi_zeta  <= degen_d[AngLat-1] ? '0 : ang_ac;
      res_r.orth_eta_zeta <= degen_d[AngLat-1] ? '0 : ang_bc;
      res_r.step_xi       <= st_d[0][AngLat-StepLat-1];
      res_r.step_eta      <= st_d[1][AngLat-StepLat-1];
      res_r.step_zeta     <= st_d[2][AngLat-StepLat-1];
    end
  end

  assign out_ch.valid = vld_r[Lat-1];
  assign out_ch.res   = res_r;
endmodule

### tb/tb_cell_quality_metrics.sv
// Self-checking testbench for the cell quality metrics pipeline.
`timescale 1ns / 100ps

module tb_cell_quality_metrics;
  import cqm_pkg::*;

  localparam int NumRandom = 1700;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 120;
  localparam int HoldStart = 400;
  localparam int HoldLen = 300;

  // coordinates in order: base, xi, eta, zeta neighbours, each x y z
  typedef logic [0:11][CoordW-1:0] cell_t;

  logic clk;
  logic rst_n;
  cqm_in_if in_ch ();
  cqm_out_if out_ch ();

  cell_quality_metrics dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  cell_t   cell_q[$];
  result_t metric_q[$];
  int      n_total;
  int      n_accepted;
  int      n_results;
  int      n_mismatch;
  int      cycles;
  int      hold_cnt;
  bit      hold_done;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned abs_val(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint shift_tz(longint v, int s);
    if (v < 0) return -longint'(longint'(-v) >> s);
    return v >> s;
  endfunction

  function automatic logic [StepW-1:0] edge_length(longint ex, longint ey, longint ez);
    longint unsigned sq;
    longint unsigned r;
    sq = (abs_val(ex) * abs_val(ex) + abs_val(ey) * abs_val(ey) +
          abs_val(ez) * abs_val(ez)) << 16;
    r = int_sqrt(sq);
    if (sq - r * r > r) r++;
    if (r > (64'd1 << StepW) - 1) r = (64'd1 << StepW) - 1;
    return StepW'(r);
  endfunction

  function automatic logic [AngW-1:0] folded_angle(longint ux, longint uy, longint uz,
                                                    longint vx, longint vy, longint vz);
    longint unsigned ad, ax, ay, az, m;
    longint x, y, z, xs, ys;
    longint unsigned q;
    int sh;
    ad = abs_val(ux * vx + uy * vy + uz * vz);
    ax = abs_val(uy * vz - uz * vy);
    ay = abs_val(uz * vx - ux * vz);
    az = abs_val(ux * vy - uy * vx);
    m = ad;
    if (ax > m) m = ax;
    if (ay > m) m = ay;
    if (az > m) m = az;
    sh = 0;
    while ((m >> sh) >= (64'd1 << 30)) sh++;
    ad = ad >> sh; ax = ax >> sh; ay = ay >> sh; az = az >> sh;
    x = longint'(ad);
    y = longint'(int_sqrt(ax * ax + ay * ay + az * az));
    z = 0;
    for (int i = 0; i < CordSteps; i++) begin
      xs = shift_tz(x, i);
      ys = shift_tz(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(atan_q16(i));
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(atan_q16(i));
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    q = (longint'(z) + 128) >> 8;
    if (q > 23040) q = 23040;
    return AngW'(q);
  endfunction

  function automatic result_t cell_metrics(cell_t c);
    result_t r;
    longint e[3][3];
    longint cx, cy, cz, jac;
    bit degen;
    degen = 0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++)
        e[i][k] = longint'(coord_t'(c[(i + 1) * 3 + k])) - longint'(coord_t'(c[k]));
      if (e[i][0] == 0 && e[i][1] == 0 && e[i][2] == 0) degen = 1;
    end
    cx = e[0][1] * e[1][2] - e[0][2] * e[1][1];
    cy = e[0][2] * e[1][0] - e[0][0] * e[1][2];
    cz = e[0][0] * e[1][1] - e[0][1] * e[1][0];
    jac = cx * e[2][0] + cy * e[2][1] + cz * e[2][2];
    r.jacobian = jac[JacW-1:0];
    if (degen) begin
      r.orth_xi_eta = '0; r.orth_xi_zeta = '0; r.orth_eta_zeta = '0;
    end else begin
      r.orth_xi_eta = folded_angle(e[0][0], e[0][1], e[0][2], e[1][0], e[1][1], e[1][2]);
      r.orth_xi_zeta = folded_angle(e[0][0], e[0][1], e[0][2], e[2][0], e[2][1], e[2][2]);
      r.orth_eta_zeta = folded_angle(e[1][0], e[1][1], e[1][2], e[2][0], e[2][1], e[2][2]);
    end
    r.step_xi = edge_length(e[0][0], e[0][1], e[0][2]);
    r.step_eta = edge_length(e[1][0], e[1][1], e[1][2]);
    r.step_zeta = edge_length(e[2][0], e[2][1], e[2][2]);
    r.degenerate = degen;
    return r;
  endfunction

  function automatic cell_t make_cell(int bx, int by, int bz, int ax, int ay, int az,
                                      int ex, int ey, int ez, int zx, int zy, int zz);
    cell_t c;
    c[0] = CoordW'(bx); c[1] = CoordW'(by); c[2] = CoordW'(bz);
    c[3] = CoordW'(bx + ax); c[4] = CoordW'(by + ay); c[5] = CoordW'(bz + az);
    c[6] = CoordW'(bx + ex); c[7] = CoordW'(by + ey); c[8] = CoordW'(bz + ez);
    c[9] = CoordW'(bx + zx); c[10] = CoordW'(by + zy); c[11] = CoordW'(bz + zz);
    return c;
  endfunction

  function automatic int small_off();
    return int'($urandom_range(0, 64)) - 32;
  endfunction

  function automatic cell_t random_cell();
    cell_t c;
    int kind;
    int bx, by, bz, ax, ay, az, k;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) c[i] = CoordW'($urandom);
    bx = $urandom_range(0, 65535) - 32768;
    by = $urandom_range(0, 65535) - 32768;
    bz = $urandom_range(0, 65535) - 32768;
    case (kind)
      6, 7: c = make_cell(bx, by, bz, small_off(), small_off(), small_off(),
                          small_off(), small_off(), small_off(),
                          small_off(), small_off(), small_off());
      8: begin
        // one neighbour sits on the base point
        k = $urandom_range(1, 3);
        c[k * 3] = c[0]; c[k * 3 + 1] = c[1]; c[k * 3 + 2] = c[2];
      end
      9: begin
        // parallel, antiparallel or perpendicular edge pairs
        ax = small_off(); ay = small_off(); az = small_off();
        k = int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1))
          c = make_cell(bx, by, bz, ax, ay, az, k * ax, k * ay, k * az,
                        small_off(), small_off(), small_off());
        else
          c = make_cell(bx, by, bz, ax, ay, 0, -ay * k, ax * k, 0, 0, 0, k + 4);
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic int idle_pct(bit is_sender);
    if (n_accepted < n_total / 3) return is_sender ? 16 : 60;
    if (n_accepted < 2 * n_total / 3) return is_sender ? 60 : 16;
    return 0;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v !== act_v) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("mismatch on result %0d, %s: expected %0h, got %0h",
                 n_results, name, exp_v, act_v);
    end
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // driver: pop pending cells, predict at each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        metric_q.push_back(cell_metrics({in_ch.base_x, in_ch.base_y, in_ch.base_z,
          in_ch.xi_nbr_x, in_ch.xi_nbr_y, in_ch.xi_nbr_z,
          in_ch.eta_nbr_x, in_ch.eta_nbr_y, in_ch.eta_nbr_z,
          in_ch.zeta_nbr_x, in_ch.zeta_nbr_y, in_ch.zeta_nbr_z}));
        n_accepted <= n_accepted + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (cell_q.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          cell_t c;
          c = cell_q.pop_front();
          in_ch.valid <= 1'b1;
          {in_ch.base_x, in_ch.base_y, in_ch.base_z,
           in_ch.xi_nbr_x, in_ch.xi_nbr_y, in_ch.xi_nbr_z,
           in_ch.eta_nbr_x, in_ch.eta_nbr_y, in_ch.eta_nbr_z,
           in_ch.zeta_nbr_x, in_ch.zeta_nbr_y, in_ch.zeta_nbr_z} <= c;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the pipeline fills and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= HoldStart) begin
      hold_cnt <= HoldLen;
      hold_done <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= idle_pct(1'b0));
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      result_t exp_r;
      n_results <= n_results + 1;
      if (metric_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("result %0d arrived with none expected", n_results);
      end else begin
        exp_r = metric_q.pop_front();
        check_field("jacobian", exp_r.jacobian, out_ch.res.jacobian);
        check_field("orth_xi_eta", exp_r.orth_xi_eta, out_ch.res.orth_xi_eta);
        check_field("orth_xi_zeta", exp_r.orth_xi_zeta, out_ch.res.orth_xi_zeta);
        check_field("orth_eta_zeta", exp_r.orth_eta_zeta, out_ch.res.orth_eta_zeta);
        check_field("step_xi", exp_r.step_xi, out_ch.res.step_xi);
        check_field("step_eta", exp_r.step_eta, out_ch.res.step_eta);
        check_field("step_zeta", exp_r.step_zeta, out_ch.res.step_zeta);
        check_field("degenerate", exp_r.degenerate, out_ch.res.degenerate);
      end
    end
  end

  initial begin
    cell_t c;
    rst_n = 1'b0;
    cycles = 0;
    n_accepted = 0;
    n_results = 0;
    n_mismatch = 0;
    in_ch.valid = 1'b0;
    {in_ch.base_x, in_ch.base_y, in_ch.base_z,
     in_ch.xi_nbr_x, in_ch.xi_nbr_y, in_ch.xi_nbr_z,
     in_ch.eta_nbr_x, in_ch.eta_nbr_y, in_ch.eta_nbr_z,
     in_ch.zeta_nbr_x, in_ch.zeta_nbr_y, in_ch.zeta_nbr_z} = '0;
    out_ch.ready = 1'b0;

    // directed cells
    cell_q.push_back('0);
    cell_q.push_back(make_cell(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1));
    cell_q.push_back(make_cell(5, -7, 9, 0, 0, 1, 0, 1, 0, 1, 0, 0));
    cell_q.push_back(make_cell(0, 0, 0, 3, 4, 0, 6, 8, 0, -3, -4, 0));
    cell_q.push_back(make_cell(0, 0, 0, 1, 1, 0, 1, 0, 0, 0, 1, 1));
    cell_q.push_back(make_cell(0, 0, 0, 2, 0, 0, 0, 0, 0, 0, 3, 0));
    cell_q.push_back(make_cell(0, 0, 0, 2, 0, 0, 0, 3, 0, 0, 0, 0));
    cell_q.push_back(make_cell(-32768, -32768, -32768, 65535, 0, 0, 0, 65535, 0, 0, 0, 65535));
    cell_q.push_back(make_cell(32767, 32767, 32767, -65535, 0, 0, 0, -65535, 0, 0, 0, -65535));
    cell_q.push_back(make_cell(-32768, -32768, -32768, 65535, 65535, 65535,
                               65535, 65535, 0, 0, 65535, 65535));
    cell_q.push_back(make_cell(-32768, 32767, -32768, 65535, -65535, 65535,
                               65535, 0, 0, 0, -65535, 0));
    cell_q.push_back(make_cell(0, 0, 0, 1000, 1, 0, 1000, 0, 0, 1, 1000, 0));
    cell_q.push_back(make_cell(0, 0, 0, 1, 0, 0, 1, 1, 0, 1, 1, 1));
    cell_q.push_back(make_cell(100, 100, 100, -1, -1, -1, 1, 1, 1, 1, -1, 0));
    c = '0;
    for (int i = 0; i < 12; i++) c[i] = (i % 2) ? 16'h7fff : 16'h8000;
    cell_q.push_back(c);
    for (int i = 0; i < 12; i++) c[i] = 16'hffff;
    c[3] = 16'h0000;
    cell_q.push_back(c);
    for (int i = 0; i < NumRandom; i++) cell_q.push_back(random_cell());
    n_total = cell_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total || metric_q.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (n_mismatch == 0 && metric_q.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### cell_quality_metrics.f
design/cqm_pkg.sv
design/cqm_if.sv
design/cqm_sqrt_cell.sv
design/cqm_cordic_cell.sv
design/cqm_angle.sv
design/cqm_step.sv
design/cell_quality_metrics.sv
tb/tb_cell_quality_metrics.sv
